@@ sv/banded_edit_distance_filter_assert.svh @@
// assertion macros used by the top rtl file
`ifndef BANDED_EDIT_DISTANCE_FILTER_ASSERT_SVH
`define BANDED_EDIT_DISTANCE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BEDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BEDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BEDF_ASSERT_NOW(lbl, ante, cons)
`define BEDF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/bedf_pkg.sv @@
package bedf_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int LETTERS = 26;
  localparam logic [7:0] LETTER_A = 8'h61;
  localparam logic [6:0] DIST_MAX = 7'd127;
  localparam logic [6:0] LIMIT_RESET = 7'd2;

  typedef enum logic [1:0] {
    KIND_FULL   = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_LETTER = 2'd2,
    KIND_ROW    = 2'd3
  } exit_kind_t;

  typedef struct packed {
    logic       func;
    logic [7:0] symbol;
    logic       last;
    logic       empty_req;
  } req_t;

  typedef struct packed {
    logic [6:0] distance;
    logic [1:0] exit_kind;
    logic       overflow;
  } rsp_t;

  typedef struct packed {
    logic       go;
    logic [6:0] limit;
  } band_cmd_t;

  typedef struct packed {
    logic done;
    logic early;
  } band_stat_t;

endpackage

@@ sv/bedf_band.sv @@
module bedf_band import bedf_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int LW = $clog2(MAX_LEN + 1),
  parameter int AW = $clog2(MAX_LEN),
  parameter int EW = ((LW > 7) ? LW : 7) + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  band_cmd_t       cmd,
  input  logic [LW-1:0]   qlen,
  input  logic [LW-1:0]   clen,
  output logic [AW-1:0]   qaddr,
  output logic [AW-1:0]   caddr,
  input  logic [7:0]      qdata,
  input  logic [7:0]      cdata,
  output band_stat_t      stat,
  output logic [EW-1:0]   value
);

  localparam int JW = $clog2(MAX_LEN + 2);
  localparam int DW = JW + 1;
  localparam int DEPTH = 2 * (MAX_LEN + 1);
  localparam int DA = $clog2(DEPTH);

  typedef enum logic [8:0] {
    B_IDLE    = 9'b000000001,
    B_INIT    = 9'b000000010,
    B_ROW     = 9'b000000100,
    B_EDGE_A  = 9'b000001000,
    B_EDGE_B  = 9'b000010000,
    B_DIAG    = 9'b000100000,
    B_CELL_RD = 9'b001000000,
    B_CELL_WR = 9'b010000000,
    B_ROW_END = 9'b100000000
  } bstate_t;

  bstate_t state;
  logic [DW-1:0] dp_mem [DEPTH];
  logic [DW-1:0] rdata;
  logic [DA-1:0] raddr, waddr;
  logic [DW-1:0] wdata;
  logic re, we;
  logic [JW-1:0] i, j, lo, hi, n, m;
  logic [6:0] t;
  logic [DW-1:0] left, diag, rmin, a_reg;
  logic [7:0] tc;
  logic [EW-1:0] i_e, t_e, lo_c, hi_c;
  logic [JW-1:0] rd_j, wr_j;
  logic rd_row, wr_row;
  logic [DW-1:0] ma, mb, v_cell, e_val, edge_r;

  always_comb begin
    i_e = EW'(i);
    t_e = EW'(t);
    lo_c = (i_e > t_e + EW'(2)) ? i_e - t_e - EW'(1) : EW'(1);
    hi_c = (i_e + t_e + EW'(1) < EW'(n)) ? i_e + t_e + EW'(1) : EW'(n);
    e_val = ((a_reg < rdata) ? a_reg : rdata) + DW'(1);
    edge_r = ((left < diag) ? left : diag) + DW'(1);
    ma = diag + ((qdata != tc) ? DW'(1) : DW'(0));
    mb = left + DW'(1);
    if (mb < ma) ma = mb;
    mb = rdata + DW'(1);
    v_cell = (mb < ma) ? mb : ma;
  end

  // memory port control
  always_comb begin
    re = 1'b0;
    we = 1'b0;
    rd_j = '0;
    wr_j = '0;
    wdata = '0;
    rd_row = ~i[0];
    wr_row = i[0];
    qaddr = AW'(j - JW'(1));
    caddr = AW'(i - JW'(1));
    unique case (state)
      B_INIT: begin
        we = 1'b1;
        wr_row = 1'b0;
        wr_j = j;
        wdata = DW'(j);
      end
      B_ROW: begin
        we = 1'b1;
        wr_j = '0;
        wdata = DW'(i);
        re = 1'b1;
        rd_j = (lo_c > EW'(1)) ? JW'(lo_c - EW'(2)) : '0;
      end
      B_EDGE_A: begin
        re = 1'b1;
        rd_j = lo - JW'(1);
      end
      B_EDGE_B: begin
        we = 1'b1;
        wr_j = lo - JW'(1);
        wdata = e_val;
      end
      B_CELL_RD: begin
        if (j <= hi) begin
          re = 1'b1;
          rd_j = j;
        end else if (j <= n) begin
          we = 1'b1;
          wr_j = j;
          wdata = edge_r;
        end
      end
      B_CELL_WR: begin
        we = 1'b1;
        wr_j = j;
        wdata = v_cell;
      end
      B_IDLE, B_DIAG, B_ROW_END: ;
      default: ;
    endcase
    raddr = rd_row ? DA'(rd_j) + DA'(MAX_LEN + 1) : DA'(rd_j);
    waddr = wr_row ? DA'(wr_j) + DA'(MAX_LEN + 1) : DA'(wr_j);
  end

  always_ff @(posedge clk) begin
    if (we) dp_mem[waddr] <= wdata;
    if (re) rdata <= dp_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      stat <= '0;
    end else begin
      stat <= '0;
      unique case (state)
        B_IDLE: begin
          if (cmd.go) begin
            n <= JW'(qlen);
            m <= JW'(clen);
            t <= cmd.limit;
            j <= '0;
            state <= B_INIT;
          end
        end
        B_INIT: begin
          if (j == n) begin
            if (m == '0) begin
              value <= EW'(n);
              stat.done <= 1'b1;
              state <= B_IDLE;
            end else begin
              i <= JW'(1);
              state <= B_ROW;
            end
          end else begin
            j <= j + JW'(1);
          end
        end
        B_ROW: begin
          lo <= JW'(lo_c);
          hi <= JW'(hi_c);
          left <= DW'(i);
          rmin <= DW'(n);
          state <= (lo_c > EW'(1)) ? B_EDGE_A : B_DIAG;
        end
        B_EDGE_A: begin
          tc <= cdata;
          a_reg <= rdata;
          state <= B_EDGE_B;
        end
        B_EDGE_B: begin
          left <= e_val;
          diag <= rdata;
          j <= lo;
          state <= B_CELL_RD;
        end
        B_DIAG: begin
          tc <= cdata;
          diag <= rdata;
          j <= lo;
          state <= B_CELL_RD;
        end
        B_CELL_RD: begin
          state <= (j <= hi) ? B_CELL_WR : B_ROW_END;
        end
        B_CELL_WR: begin
          left <= v_cell;
          diag <= rdata;
          if (v_cell < rmin) rmin <= v_cell;
          j <= j + JW'(1);
          state <= B_CELL_RD;
        end
        B_ROW_END: begin
          if (EW'(rmin) > EW'(t)) begin
            value <= EW'(rmin);
            stat.done <= 1'b1;
            stat.early <= 1'b1;
            state <= B_IDLE;
          end else if (i == m) begin
            value <= EW'(left);
            stat.done <= 1'b1;
            state <= B_IDLE;
          end else begin
            i <= i + JW'(1);
            state <= B_ROW;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ sv/banded_edit_distance_filter.sv @@
// channel   | ports                   | transfer when
// ----------+-------------------------+------------------------------
// item in   | start, busy, req        | start high and busy low
// result    | done, result            | done high (one cycle, no stall)
// limit     | limit_we, limit_wdata   | limit_we high
//
// a query character or a non-final candidate character is loaded and leaves busy low
// the final candidate character (or an empty candidate) runs the filters:
//   the length test, the letter sums letter by letter, then the band walk
//   of row 0 and each further row: row setup, an edge cell if any, the band
//   cells (each read then written via one dp port pair) and the row end
// reset clears lengths, flags and letter counts and sets the limit to 2
// the result receiver cannot stall; busy holds off new items meanwhile
module banded_edit_distance_filter import bedf_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output rsp_t       result,
  input  logic       limit_we,
  input  logic [6:0] limit_wdata
);

`include "banded_edit_distance_filter_assert.svh"

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int EW = ((LW > 7) ? LW : 7) + 2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LEN    = 4'b0010,
    S_LETTER = 4'b0100,
    S_BAND   = 4'b1000
  } state_t;

  state_t state;
  logic [6:0] limit;

  // character stores and their read ports for the band walk
  logic [7:0] qmem [MAX_LEN];
  logic [7:0] cmem [MAX_LEN];
  logic [7:0] qdata, cdata;
  logic [AW-1:0] qaddr, caddr;

  // string state
  logic [LW-1:0] q_len, c_len;
  logic q_ovf, c_ovf, q_open, c_open;
  logic [LW-1:0] qcnt [LETTERS];
  logic [LW-1:0] ccnt [LETTERS];

  // letter filter
  logic [4:0] lidx;
  logic [EW-1:0] exc, bel, exc_sum, bel_sum, diff, t_e;
  logic [LW-1:0] qsel, csel;

  // load decode
  logic take;
  logic is_letter;
  logic [4:0] letter;
  logic [LW-1:0] q_base, c_base;
  logic q_room, c_room;

  band_cmd_t  bcmd;
  band_stat_t bstat;
  logic [EW-1:0] bvalue;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;
  assign is_letter = (req.symbol >= LETTER_A) && (req.symbol < LETTER_A + 8'(LETTERS));
  assign letter = 5'(req.symbol - LETTER_A);
  // a closed string restarts from zero on its first character
  assign q_base = q_open ? q_len : '0;
  assign c_base = c_open ? c_len : '0;
  assign q_room = (EW'(q_base) < EW'(MAX_LEN));
  assign c_room = (EW'(c_base) < EW'(MAX_LEN));

  assign t_e = EW'(limit);
  assign qsel = qcnt[lidx];
  assign csel = ccnt[lidx];
  assign exc_sum = exc + EW'(qsel - csel);
  assign bel_sum = bel + EW'(csel - qsel);
  assign diff = (q_len > c_len) ? EW'(q_len - c_len) : EW'(c_len - q_len);

  function automatic logic [6:0] sat(input logic [EW-1:0] v);
    return (v > EW'(DIST_MAX)) ? DIST_MAX : v[6:0];
  endfunction

  // character memories: written on load, read by the band walk
  always_ff @(posedge clk) begin
    if (take && !req.empty_req && !req.func && q_room) qmem[AW'(q_base)] <= req.symbol;
    if (take && !req.empty_req && req.func && c_room) cmem[AW'(c_base)] <= req.symbol;
    qdata <= qmem[qaddr];
    cdata <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (limit_we) begin
      limit <= limit_wdata;
    end
  end

  // string loading
  always_ff @(posedge clk) begin
    if (rst) begin
      q_len <= '0;
      c_len <= '0;
      q_ovf <= 1'b0;
      c_ovf <= 1'b0;
      q_open <= 1'b0;
      c_open <= 1'b0;
      for (int k = 0; k < LETTERS; k++) begin
        qcnt[k] <= '0;
        ccnt[k] <= '0;
      end
    end else if (take) begin
      if (!req.func) begin
        if (req.empty_req) begin
          q_len <= '0;
          q_ovf <= 1'b0;
          q_open <= 1'b0;
          for (int k = 0; k < LETTERS; k++) qcnt[k] <= '0;
        end else begin
          q_open <= !req.last;
          q_len <= q_room ? q_base + LW'(1) : q_base;
          q_ovf <= (q_open && q_ovf) || !q_room;
          for (int k = 0; k < LETTERS; k++) begin
            qcnt[k] <= (q_open ? qcnt[k] : '0) +
                       ((q_room && is_letter && letter == 5'(k)) ? LW'(1) : LW'(0));
          end
        end
      end else begin
        if (req.empty_req) begin
          c_len <= '0;
          c_ovf <= 1'b0;
          c_open <= 1'b0;
          for (int k = 0; k < LETTERS; k++) ccnt[k] <= '0;
        end else begin
          c_open <= !req.last;
          c_len <= c_room ? c_base + LW'(1) : c_base;
          c_ovf <= (c_open && c_ovf) || !c_room;
          for (int k = 0; k < LETTERS; k++) begin
            ccnt[k] <= (c_open ? ccnt[k] : '0) +
                       ((c_room && is_letter && letter == 5'(k)) ? LW'(1) : LW'(0));
          end
        end
      end
    end
  end

  // filter sequence and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      bcmd <= '0;
    end else begin
      done <= 1'b0;
      bcmd.go <= 1'b0;
      bcmd.limit <= limit;
      unique case (state)
        S_IDLE: begin
          if (take && req.func && (req.empty_req || req.last)) state <= S_LEN;
        end
        S_LEN: begin
          result.overflow <= q_ovf || c_ovf;
          if (diff > t_e) begin
            result.distance <= sat(diff);
            result.exit_kind <= KIND_LENGTH;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            lidx <= '0;
            exc <= '0;
            bel <= '0;
            state <= S_LETTER;
          end
        end
        S_LETTER: begin
          if (qsel > csel && exc_sum > t_e) begin
            result.distance <= sat(exc_sum);
            result.exit_kind <= KIND_LETTER;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (qsel <= csel && bel_sum > t_e) begin
            result.distance <= sat(bel_sum);
            result.exit_kind <= KIND_LETTER;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (qsel > csel) exc <= exc_sum;
            else bel <= bel_sum;
            lidx <= lidx + 5'd1;
            if (lidx == 5'(LETTERS - 1)) begin
              bcmd.go <= 1'b1;
              state <= S_BAND;
            end
          end
        end
        S_BAND: begin
          if (bstat.done) begin
            result.distance <= sat(bvalue);
            result.exit_kind <= bstat.early ? KIND_ROW : KIND_FULL;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bedf_band #(
    .MAX_LEN(MAX_LEN),
    .LW(LW),
    .AW(AW),
    .EW(EW)
  ) u_band (
    .clk(clk),
    .rst(rst),
    .cmd(bcmd),
    .qlen(q_len),
    .clen(c_len),
    .qaddr(qaddr),
    .caddr(caddr),
    .qdata(qdata),
    .cdata(cdata),
    .stat(bstat),
    .value(bvalue)
  );

  // a finished candidate always starts the filters
  `BEDF_ASSERT_NEXT(a_cand_end_busy, take && req.func && (req.empty_req || req.last), busy)
  // query characters never block the input
  `BEDF_ASSERT_NEXT(a_query_no_busy, take && !req.func, !busy)
  // a result only closes a filter run
  `BEDF_ASSERT_NOW(a_done_after_busy, done, $past(busy) && !busy)

endmodule
